### sv/ilha_pkg.sv
// ============================================================================
// ilha_pkg
// Shared types and constants of the implicit list heap allocator: transfer
// payloads, command and status codes, and the controller/datapath link.
// ============================================================================
package ilha_pkg;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_HEAP_UNITS = 1'd0;
   localparam logic [12:0] HEAP_UNITS_RESET = 13'd4096;

   localparam int DIV_BITS = 17;

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOFIT   = 2'd1;
   localparam logic [1:0] STATUS_REFUSED = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] request_bytes;
      logic [14:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] payload_offset;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic init;
      logic divide;
      logic probe;
      logic test;
      logic tail;
      logic fcheck;
      logic ftest;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       walk_in;
      logic       fits;
      logic       last;
      logic       tail_room;
      logic       free_ok;
   } dp_stat_type;

endpackage

### sv/ilha_ram.sv
// ============================================================================
// ilha_ram
// Generic single-port-write, single-port-read memory with registered read.
// ============================================================================
module ilha_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ilha_datapath.sv
// ============================================================================
// ilha_datapath
// Allocator datapath: header memory, walk pointer, list bookkeeping, the
// reciprocal divider for unit rounding and offset decoding, and the result
// registers.
// ============================================================================
module ilha_datapath
   import ilha_pkg::*;
#(
   parameter int HEAP_UNITS        = 4096,
   parameter int ALIGN_BYTES       = 8,
   parameter int MAX_REQUEST_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic [12:0] heap_units,
   input  dp_cmd_type  dp_cmd,
   output dp_stat_type dp_stat,
   output rsp_type     rsp_data
);

   localparam int AW  = $clog2(HEAP_UNITS);
   localparam int VW  = $clog2(HEAP_UNITS + 1);
   localparam int HW  = VW + 1;
   localparam int WW  = AW + 1;
   localparam int SW  = ((HW > DIV_BITS) ? HW : DIV_BITS) + 1;
   localparam int QAW = DIV_BITS + $clog2(ALIGN_BYTES + 1);
   localparam int RECIP_SHIFT = DIV_BITS + $clog2(ALIGN_BYTES);
   localparam int PRW = RECIP_SHIFT + DIV_BITS;
   localparam longint RECIP =
      ((longint'(1) << RECIP_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int LIVE_RESET = (HEAP_UNITS < 4096) ? HEAP_UNITS : 4096;

   logic [1:0]          cmd_ff;
   logic [DIV_BITS-1:0] x_ff;
   logic [DIV_BITS-1:0] q_ff;
   logic [HW-1:0]       h_ff;
   logic [VW-1:0]       n_ff;
   logic [AW-1:0]       frontier_ff;
   logic [VW-1:0]       count_ff;
   logic [VW-1:0]       live_ff;
   logic [1:0]          res_status_ff;
   logic [14:0]         res_payload_ff;
   rsp_type             rsp_data_ff;

   logic [VW-1:0]       units;
   logic                init_ok;
   logic [PRW-1:0]      prod;
   logic [QAW-1:0]      qa;
   logic [DIV_BITS-1:0] unit;
   logic [WW-1:0]       word;
   logic                used;
   logic [AW-1:0]       sz;
   logic [SW-1:0]       nf;
   logic [14:0]         take_payload;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [WW-1:0]       wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;

   always_comb begin
      if (heap_units < 13'd2) begin
         units = VW'(2);
      end else if (32'(heap_units) > HEAP_UNITS) begin
         units = VW'(HEAP_UNITS);
      end else begin
         units = VW'(heap_units);
      end
   end

   assign init_ok = (32'(units) * 32'(ALIGN_BYTES)) >= 32'(MAX_REQUEST_BYTES);
   assign prod    = PRW'(x_ff) * PRW'(RECIP);
   assign qa      = QAW'(q_ff) * QAW'(ALIGN_BYTES);
   assign unit    = q_ff - DIV_BITS'(1);
   assign used    = word[0];
   assign sz      = word[AW:1];
   assign nf      = SW'(h_ff) + SW'(q_ff) + SW'(1);
   assign take_payload = 15'((32'(h_ff) + 32'd1) * 32'(ALIGN_BYTES));

   assign dp_stat.command   = cmd_ff;
   assign dp_stat.walk_in   = (32'(h_ff) <= 32'(frontier_ff)) && (32'(h_ff) < 32'(live_ff));
   assign dp_stat.fits      = !used && (32'(sz) >= 32'(q_ff));
   assign dp_stat.last      = (32'(n_ff) + 32'd1) == 32'(count_ff);
   assign dp_stat.tail_room = (32'(nf) + 32'd1) < 32'(live_ff);
   assign dp_stat.free_ok   = (x_ff != '0) && (qa == QAW'(x_ff)) &&
                              (32'(unit) < 32'(live_ff)) && (32'(unit) < HEAP_UNITS);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = h_ff[AW-1:0];
      wr_data = {sz, 1'b1};
      rd_en   = 1'b0;
      rd_addr = h_ff[AW-1:0];
      if (dp_cmd.init) begin
         wr_en   = init_ok;
         wr_addr = '0;
         wr_data = {AW'(units - VW'(1)), 1'b0};
      end
      if (dp_cmd.test && dp_stat.fits) begin
         wr_en = 1'b1;
         if (dp_stat.last && dp_stat.tail_room) begin
            wr_data = {AW'(q_ff), 1'b1};
         end else if (dp_stat.last) begin
            wr_data = {AW'(32'(live_ff) - 32'd1 - 32'(h_ff)), 1'b1};
         end
      end
      if (dp_cmd.tail) begin
         wr_en   = 1'b1;
         wr_data = {AW'(32'(live_ff) - 32'd1 - 32'(h_ff)), 1'b0};
      end
      if (dp_cmd.ftest) begin
         wr_en   = used;
         wr_data = {sz, 1'b0};
      end
      if (dp_cmd.probe) begin
         rd_en = dp_stat.walk_in;
      end
      if (dp_cmd.fcheck) begin
         rd_en   = dp_stat.free_ok;
         rd_addr = AW'(unit);
      end
   end

   ilha_ram #(
      .WIDTH(WW),
      .DEPTH(HEAP_UNITS)
   ) u_header_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frontier_ff <= '0;
         count_ff    <= VW'(1);
         live_ff     <= VW'(LIVE_RESET);
      end else begin
         if (dp_cmd.init && init_ok) begin
            frontier_ff <= '0;
            count_ff    <= VW'(1);
            live_ff     <= units;
         end
         if (dp_cmd.tail) begin
            frontier_ff <= h_ff[AW-1:0];
            count_ff    <= count_ff + VW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff         <= req_data.command;
         res_payload_ff <= '0;
         if (req_data.command == CMD_ALLOC) begin
            x_ff          <= DIV_BITS'(req_data.request_bytes) + DIV_BITS'(ALIGN_BYTES - 1);
            res_status_ff <= STATUS_NOFIT;
         end else begin
            x_ff          <= DIV_BITS'(req_data.block_offset);
            res_status_ff <= STATUS_IGNORED;
         end
      end
      if (dp_cmd.init) begin
         res_status_ff <= init_ok ? STATUS_OK : STATUS_REFUSED;
      end
      if (dp_cmd.divide) begin
         q_ff <= prod[RECIP_SHIFT +: DIV_BITS];
         h_ff <= '0;
         n_ff <= '0;
      end
      if (dp_cmd.test) begin
         n_ff <= n_ff + VW'(1);
         if (!dp_stat.fits) begin
            h_ff <= h_ff + HW'(sz) + HW'(1);
         end else begin
            res_status_ff  <= STATUS_OK;
            res_payload_ff <= take_payload;
            if (dp_stat.last && dp_stat.tail_room) begin
               h_ff <= HW'(nf);
            end
         end
      end
      if (dp_cmd.fcheck) begin
         h_ff <= HW'(unit);
      end
      if (dp_cmd.ftest && used) begin
         res_status_ff <= STATUS_OK;
      end
      if (dp_cmd.load_rsp) begin
         rsp_data_ff.status         <= res_status_ff;
         rsp_data_ff.payload_offset <= res_payload_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

### sv/ilha_ctrl.sv
// ============================================================================
// ilha_ctrl
// Allocator sequencer: dispatches each command, steps the header walk and
// hands finished results to the output register.
// ============================================================================
module ilha_ctrl
   import ilha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  dp_cmd,
   input  dp_stat_type dp_stat
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_DIV,
      ST_PROBE,
      ST_TEST,
      ST_TAIL,
      ST_FCHK,
      ST_FTEST,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      dp_cmd       = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               case (req_command)
                  CMD_INIT:  state_in = ST_INIT;
                  CMD_ALLOC: state_in = ST_DIV;
                  CMD_FREE:  state_in = ST_DIV;
                  default:   state_in = ST_FIN;
               endcase
            end
         end
         ST_INIT: begin
            dp_cmd.init = 1'b1;
            state_in    = ST_FIN;
         end
         ST_DIV: begin
            dp_cmd.divide = 1'b1;
            state_in = (dp_stat.command == CMD_ALLOC) ? ST_PROBE : ST_FCHK;
         end
         ST_PROBE: begin
            dp_cmd.probe = 1'b1;
            state_in     = dp_stat.walk_in ? ST_TEST : ST_FIN;
         end
         ST_TEST: begin
            dp_cmd.test = 1'b1;
            if (!dp_stat.fits) begin
               state_in = ST_PROBE;
            end else if (dp_stat.last && dp_stat.tail_room) begin
               state_in = ST_TAIL;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_TAIL: begin
            dp_cmd.tail = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FCHK: begin
            dp_cmd.fcheck = 1'b1;
            state_in      = dp_stat.free_ok ? ST_FTEST : ST_FIN;
         end
         ST_FTEST: begin
            dp_cmd.ftest = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               dp_cmd.load_rsp = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/implicit_list_heap_allocator.sv
// ============================================================================
// implicit_list_heap_allocator
// First-fit heap allocator over an implicit list of block headers kept in an
// on-chip memory of HEAP_UNITS words. One command is processed at a time and
// each produces exactly one result transfer. A free decodes its offset and,
// when it is valid, reads and frees the addressed block if used; an unknown
// command goes straight to its result. An allocate rounds its request up to
// units, then reads and tests headers one after another until a block fits
// or the walk leaves the heap, splitting the last block with a new tail
// header where room allows; each header comes from the registered read port
// of the header memory and is tested before the next is read. A new command
// is accepted while the previous result is still waiting in the output
// register. The heap size register sits at byte address 0 and takes effect
// on the next successful init.
module implicit_list_heap_allocator
   import ilha_pkg::*;
#(
   parameter int HEAP_UNITS        = 4096,
   parameter int ALIGN_BYTES       = 8,
   parameter int MAX_REQUEST_BYTES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [12:0]            heap_units_ff;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_write;
   dp_cmd_type             dp_cmd;
   dp_stat_type            dp_stat;

   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_HEAP_UNITS) ? 32'(heap_units_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_units_ff <= HEAP_UNITS_RESET;
      end else if (csr_write && (csr_index == REG_HEAP_UNITS)) begin
         heap_units_ff <= csr_pwdata[12:0];
      end
   end

   ilha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_command(req_data.command),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat)
   );

   ilha_datapath #(
      .HEAP_UNITS       (HEAP_UNITS),
      .ALIGN_BYTES      (ALIGN_BYTES),
      .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .heap_units(heap_units_ff),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat),
      .rsp_data  (rsp_data)
   );

   // Only one command is in flight: an accepted transfer closes the input.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a command is in flight");

   // Only a successful allocate carries a payload offset.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_OK)) |-> (rsp_data.payload_offset == 15'd0))
      else $error("payload offset on a result that is not a successful allocate");

   // A result is loaded only as the sequencer returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result loaded while the sequencer is busy");

endmodule

### tb/implicit_list_heap_allocator_test.sv
`timescale 1ns / 100ps
// ============================================================================
// implicit_list_heap_allocator_test
// Self-checking test of the first-fit heap allocator. A directed opening
// exercises init, allocation with reuse of inner blocks, the tail taking the
// rest of the heap, no fit, and ignored frees of zero, unaligned and unused
// offsets. Random phases then mix allocations and frees of live blocks with
// noise under several heap sizes, some of them refused. Every result transfer
// is compared against an in-order prediction kept by the test.
// ============================================================================
module implicit_list_heap_allocator_test;
   import ilha_pkg::*;

   localparam int HEAP_DEPTH   = 4096;
   localparam int ALIGN        = 8;
   localparam int MAX_REQUEST  = 1024;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 283;
   localparam int TOTAL_ITEMS  = PHASES * PHASE_ITEMS + 21;
   localparam int STALL_LIMIT  = 60000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   req_type pending_cmds[$];
   rsp_type expected_rsp[$];
   rsp_type oldest_rsp;
   int unsigned live_offsets[$];
   int unsigned written_units[$];

   logic [12:0] heap_units_reg = HEAP_UNITS_RESET;
   int unsigned live_units = HEAP_UNITS_RESET;
   int unsigned frontier = 0;
   int unsigned header_total = 1;
   int unsigned hdr_size [HEAP_DEPTH];
   bit hdr_used [HEAP_DEPTH];
   bit hdr_written [HEAP_DEPTH];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int issued = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   int phase;

   implicit_list_heap_allocator #(
      .HEAP_UNITS(HEAP_DEPTH),
      .ALIGN_BYTES(ALIGN),
      .MAX_REQUEST_BYTES(MAX_REQUEST)
   ) uut (.*);

   always #6 clock = ~clock;

   function automatic void write_header(int unsigned unit, int unsigned size, bit used);
      hdr_size[unit] = size;
      hdr_used[unit] = used;
      if (!hdr_written[unit]) begin
         hdr_written[unit] = 1'b1;
         written_units.push_back(unit);
      end
   endfunction

   function automatic rsp_type run_allocator(req_type cmd);
      rsp_type result;
      int unsigned units, need, h, n, nf, unit;
      int i;
      bit found;
      result.status = STATUS_IGNORED;
      result.payload_offset = '0;
      case (cmd.command)
         CMD_INIT: begin
            units = (heap_units_reg < 2) ? 2 :
                    (heap_units_reg > HEAP_DEPTH) ? HEAP_DEPTH : heap_units_reg;
            if (units * ALIGN < MAX_REQUEST) begin
               result.status = STATUS_REFUSED;
            end else begin
               live_units = units;
               write_header(0, units - 1, 1'b0);
               frontier = 0;
               header_total = 1;
               live_offsets.delete();
               result.status = STATUS_OK;
            end
         end
         CMD_ALLOC: begin
            need = (int'(cmd.request_bytes) + ALIGN - 1) / ALIGN;
            h = 0;
            n = 0;
            found = 1'b0;
            result.status = STATUS_NOFIT;
            while (!found && h <= frontier && h < live_units) begin
               n++;
               if (!hdr_used[h] && hdr_size[h] >= need) found = 1'b1;
               else h = h + 1 + hdr_size[h];
            end
            if (found) begin
               if (n == header_total) begin
                  nf = h + 1 + need;
                  if (nf >= live_units - 1) begin
                     write_header(h, live_units - 1 - h, 1'b1);
                  end else begin
                     write_header(h, need, 1'b1);
                     write_header(nf, live_units - nf - 1, 1'b0);
                     frontier = nf;
                     header_total++;
                  end
               end else begin
                  hdr_used[h] = 1'b1;
               end
               result.status = STATUS_OK;
               result.payload_offset = 15'((h + 1) * ALIGN);
               live_offsets.push_back((h + 1) * ALIGN);
            end
         end
         CMD_FREE: begin
            if (cmd.block_offset != 0 && cmd.block_offset % ALIGN == 0) begin
               unit = cmd.block_offset / ALIGN - 1;
               if (unit < live_units && hdr_used[unit]) begin
                  hdr_used[unit] = 1'b0;
                  result.status = STATUS_OK;
                  for (i = live_offsets.size() - 1; i >= 0; i--) begin
                     if (live_offsets[i] == cmd.block_offset) live_offsets.delete(i);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(run_allocator(req_data));
         end
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data <= pending_cmds.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               $error("unexpected result transfer: status %0d, payload_offset %0d",
                      rsp_data.status, rsp_data.payload_offset);
            end else begin
               oldest_rsp = expected_rsp.pop_front();
               if (rsp_data.status !== oldest_rsp.status) begin
                  mismatches++;
                  $error("status: expected %0d, actual %0d",
                         oldest_rsp.status, rsp_data.status);
               end
               if (rsp_data.payload_offset !== oldest_rsp.payload_offset) begin
                  mismatches++;
                  $error("payload_offset: expected %0d, actual %0d",
                         oldest_rsp.payload_offset, rsp_data.payload_offset);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic drain();
      while (pending_cmds.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(negedge clock);
   endtask

   task automatic issue(logic [1:0] command, int unsigned request, int unsigned offset);
      req_type item;
      item.command = command;
      item.request_bytes = 16'(request);
      item.block_offset = 15'(offset);
      while (pending_cmds.size() >= 2) @(negedge clock);
      if (issued < TOTAL_ITEMS / 3) begin
         send_idle_pct = 38;
         recv_idle_pct = 73;
      end else if (issued < 2 * TOTAL_ITEMS / 3) begin
         send_idle_pct = 73;
         recv_idle_pct = 38;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      pending_cmds.push_back(item);
      issued++;
      // The heap bounds used to pick free offsets change only at an init.
      if (command == CMD_INIT) drain();
   endtask

   task automatic write_heap_units(int unsigned units);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(4 * REG_HEAP_UNITS);
      csr_pwdata <= 32'(units);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      heap_units_reg = units[12:0];
   endtask

   task automatic random_command();
      int pick, sub_pick;
      int unsigned request, offset, unit;
      logic [1:0] command;
      pick = $urandom_range(0, 99);
      sub_pick = $urandom_range(0, 99);
      request = $urandom_range(0, 32768);
      offset = $urandom_range(0, 32767);
      if (pick < 3) begin
         command = CMD_INIT;
      end else if (pick < 5) begin
         command = CMD_UNKNOWN;
      end else if (pick < 57) begin
         command = CMD_ALLOC;
         if (sub_pick < 55) request = $urandom_range(0, 256);
         else if (sub_pick < 80) request = $urandom_range(0, MAX_REQUEST);
         else if (sub_pick < 88) request = ALIGN * $urandom_range(0, 32);
         else if (sub_pick < 95) request = $urandom_range(0, 32768);
         else request = (sub_pick < 97) ? 0 : 32768;
      end else begin
         command = CMD_FREE;
         if (sub_pick < 70 && live_offsets.size() > 0) begin
            offset = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
         end else if (sub_pick < 80) begin
            unit = written_units[$urandom_range(0, written_units.size() - 1)];
            offset = (unit + 1) * ALIGN;
         end else if (sub_pick < 86) begin
            offset = 0;
         end else if (sub_pick < 93 || live_units >= HEAP_DEPTH - 1) begin
            offset = offset | 1;
         end else begin
            offset = ALIGN * ($urandom_range(live_units, HEAP_DEPTH - 2) + 1);
         end
      end
      issue(command, request, offset);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      issue(CMD_INIT, 0, 0);
      issue(CMD_ALLOC, 0, 32767);
      issue(CMD_ALLOC, 1, 0);
      issue(CMD_ALLOC, MAX_REQUEST, 0);
      issue(CMD_ALLOC, ALIGN, 0);
      issue(CMD_FREE, 32768, 2 * ALIGN);
      issue(CMD_FREE, 0, 2 * ALIGN);
      issue(CMD_ALLOC, 3, 0);
      issue(CMD_FREE, 0, 0);
      issue(CMD_FREE, 0, 32767);
      issue(CMD_ALLOC, 32768, 0);
      issue(CMD_UNKNOWN, 32768, 32767);
      issue(CMD_ALLOC, 3960 * ALIGN, 0);
      issue(CMD_ALLOC, ALIGN, 0);
      issue(CMD_FREE, 0, ALIGN);
      issue(CMD_ALLOC, 0, 0);
      issue(CMD_FREE, 0, 135 * ALIGN);
      issue(CMD_ALLOC, 32768, 0);
      issue(CMD_INIT, 32768, 32767);
      issue(CMD_ALLOC, (HEAP_DEPTH - 2) * ALIGN, 0);
      issue(CMD_FREE, 0, ALIGN);

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            drain();
            case (phase)
               1: write_heap_units(MAX_REQUEST / ALIGN);
               2: write_heap_units(2);
               3: write_heap_units(HEAP_DEPTH);
               4: write_heap_units(MAX_REQUEST / ALIGN - 1);
               default: write_heap_units($urandom_range(MAX_REQUEST / ALIGN, HEAP_DEPTH));
            endcase
            @(negedge clock);
            issue(CMD_INIT, $urandom_range(0, 32768), $urandom_range(0, 32767));
         end
         repeat (PHASE_ITEMS) random_command();
      end

      drain();
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
sv/ilha_pkg.sv
sv/ilha_ram.sv
sv/ilha_datapath.sv
sv/ilha_ctrl.sv
sv/implicit_list_heap_allocator.sv
tb/implicit_list_heap_allocator_test.sv
